[src/rounded_box_circle_pushout_core_macros.svh]
// assertion macros shared by the push-out checker
`ifndef ROUNDED_BOX_CIRCLE_PUSHOUT_CORE_MACROS_SVH
`define ROUNDED_BOX_CIRCLE_PUSHOUT_CORE_MACROS_SVH

// consequent checked in the same cycle
`define RBCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define RBCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rbcp_pkg.sv]
// types, constants and step functions of the rounded box push-out core
package rbcp_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned TR_W       = SQ_W + 2;
  localparam int unsigned NUM_W      = 64;
  localparam int unsigned DEN_W      = 32;
  localparam int unsigned QUOT_W     = 34;
  localparam int unsigned DS_W       = DEN_W + QUOT_W;
  localparam int unsigned OUT_W      = 65;

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_HALF_WIDTH,
    REG_HALF_HEIGHT,
    REG_CORNER_RADIUS,
    REG_COS_ANGLE,
    REG_SIN_ANGLE
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_ZERO,
    MODE_AXIS_X,
    MODE_AXIS_Y,
    MODE_CORNER,
    MODE_OUTSIDE
  } mode_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    mode_e       mode;
    logic        neg_x;
    logic        neg_y;
  } sq_side_t;

  typedef struct packed {
    logic [32:0] axis_v;
    mode_e       mode;
    logic        neg_x;
    logic        neg_y;
  } dv_side_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sq_step_t;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
  } dv_step_t;

  // one result bit of the integer square root
  function automatic sq_step_t sqrt_step(input logic [SQ_W-1:0] rem,
                                         input logic [ROOT_W-1:0] root,
                                         input int unsigned k);
    logic [TR_W-1:0] tr;
    sq_step_t        res;
    tr = (TR_W'(root) << (k + 1)) | (TR_W'(1) << (2 * k));
    res.rem  = rem;
    res.root = root;
    if (TR_W'(rem) >= tr) begin
      res.rem  = rem - tr[SQ_W-1:0];
      res.root = root | (ROOT_W'(1) << k);
    end
    return res;
  endfunction

  // one quotient bit of restoring division
  function automatic dv_step_t div_step(input logic [NUM_W-1:0] rem,
                                        input logic [QUOT_W-1:0] quot,
                                        input logic [DEN_W-1:0] den,
                                        input int unsigned k);
    logic [DS_W-1:0] ds;
    dv_step_t        res;
    ds = DS_W'(den) << k;
    res.rem  = rem;
    res.quot = quot;
    if (DS_W'(rem) >= ds) begin
      res.rem  = rem - ds[NUM_W-1:0];
      res.quot = quot | (QUOT_W'(1) << k);
    end
    return res;
  endfunction

  // clamp a rounded world component to 32 bits signed
  function automatic logic [31:0] sat_w(input logic [38:0] w);
    logic [31:0] res;
    if (w[38:31] == {8{w[31]}}) begin
      res = w[31:0];
    end else if (w[38]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7fff_ffff;
    end
    return res;
  endfunction

endpackage

[src/rbcp_sqrt_pipe.sv]
// two-lane pipelined integer square root, one result bit per stage
module rbcp_sqrt_pipe #(
  parameter int unsigned SideW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rbcp_pkg::SQ_W-1:0] rad_a_i,
  input  logic [rbcp_pkg::SQ_W-1:0] rad_b_i,
  input  logic [SideW-1:0]          side_i,
  output logic                      valid_o,
  output logic [rbcp_pkg::ROOT_W-1:0] root_a_o,
  output logic [rbcp_pkg::ROOT_W-1:0] root_b_o,
  output logic [SideW-1:0]          side_o
);
  import rbcp_pkg::*;

  localparam int unsigned Stages = ROOT_W;

  logic              vld_q [Stages];
  sq_step_t          a_q   [Stages];
  sq_step_t          b_q   [Stages];
  sq_step_t          a_d   [Stages];
  sq_step_t          b_d   [Stages];
  logic [SideW-1:0]  side_q[Stages];

  always_comb begin
    for (int unsigned j = 0; j < Stages; j++) begin
      if (j == 0) begin
        a_d[j] = sqrt_step(rad_a_i, '0, Stages - 1);
        b_d[j] = sqrt_step(rad_b_i, '0, Stages - 1);
      end else begin
        a_d[j] = sqrt_step(a_q[j-1].rem, a_q[j-1].root, Stages - 1 - j);
        b_d[j] = sqrt_step(b_q[j-1].rem, b_q[j-1].root, Stages - 1 - j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned j = 0; j < Stages; j++) vld_q[j] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int unsigned j = 1; j < Stages; j++) vld_q[j] <= vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int unsigned j = 1; j < Stages; j++) side_q[j] <= side_q[j-1];
      for (int unsigned j = 0; j < Stages; j++) begin
        a_q[j] <= a_d[j];
        b_q[j] <= b_d[j];
      end
    end
  end

  assign valid_o  = vld_q[Stages-1];
  assign root_a_o = a_q[Stages-1].root;
  assign root_b_o = b_q[Stages-1].root;
  assign side_o   = side_q[Stages-1];

endmodule

[src/rbcp_div_pipe.sv]
// two-lane pipelined restoring divider over a shared divisor, one quotient bit per stage
module rbcp_div_pipe #(
  parameter int unsigned SideW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rbcp_pkg::NUM_W-1:0]  num_x_i,
  input  logic [rbcp_pkg::NUM_W-1:0]  num_y_i,
  input  logic [rbcp_pkg::DEN_W-1:0]  den_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        valid_o,
  output logic [rbcp_pkg::QUOT_W-1:0] quot_x_o,
  output logic [rbcp_pkg::QUOT_W-1:0] quot_y_o,
  output logic [SideW-1:0]            side_o
);
  import rbcp_pkg::*;

  localparam int unsigned Stages = QUOT_W;

  logic              vld_q [Stages];
  dv_step_t          x_q   [Stages];
  dv_step_t          y_q   [Stages];
  dv_step_t          x_d   [Stages];
  dv_step_t          y_d   [Stages];
  logic [DEN_W-1:0]  den_q [Stages];
  logic [SideW-1:0]  side_q[Stages];

  always_comb begin
    for (int unsigned j = 0; j < Stages; j++) begin
      if (j == 0) begin
        x_d[j] = div_step(num_x_i, '0, den_i, Stages - 1);
        y_d[j] = div_step(num_y_i, '0, den_i, Stages - 1);
      end else begin
        x_d[j] = div_step(x_q[j-1].rem, x_q[j-1].quot, den_q[j-1], Stages - 1 - j);
        y_d[j] = div_step(y_q[j-1].rem, y_q[j-1].quot, den_q[j-1], Stages - 1 - j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned j = 0; j < Stages; j++) vld_q[j] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int unsigned j = 1; j < Stages; j++) vld_q[j] <= vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      den_q[0]  <= den_i;
      for (int unsigned j = 1; j < Stages; j++) begin
        side_q[j] <= side_q[j-1];
        den_q[j]  <= den_q[j-1];
      end
      for (int unsigned j = 0; j < Stages; j++) begin
        x_q[j] <= x_d[j];
        y_q[j] <= y_d[j];
      end
    end
  end

  assign valid_o  = vld_q[Stages-1];
  assign quot_x_o = x_q[Stages-1].quot;
  assign quot_y_o = y_q[Stages-1].quot;
  assign side_o   = side_q[Stages-1];

endmodule

[src/rbcp_out_buf.sv]
// two-entry output buffer that decouples the pipeline from the result stream
module rbcp_out_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [rbcp_pkg::OUT_W-1:0] data_i,
  output logic                       ready_o,
  output logic                       valid_o,
  input  logic                       pop_ready_i,
  output logic [rbcp_pkg::OUT_W-1:0] data_o
);
  import rbcp_pkg::*;

  logic [1:0]       cnt_q, cnt_d;
  logic [OUT_W-1:0] e0_q, e0_d, e1_q, e1_d;
  logic             pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && pop_ready_i;
  assign ready_o = (cnt_q != 2'd2) || pop_ready_i;
  assign data_o  = e0_q;

  always_comb begin
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
    e0_d  = e0_q;
    e1_d  = e1_q;
    if (pop) begin
      e0_d = (cnt_q == 2'd2) ? e1_q : data_i;
      if (push_i && (cnt_q == 2'd2)) e1_d = data_i;
    end else if (push_i) begin
      if (cnt_q == 2'd0) e0_d = data_i;
      else e1_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

[src/rounded_box_circle_pushout_core.sv]
// a circle item passes stages s1 to s6, the square root, p1 to p3, the divider and f1 to f3 into the output buffer
// throughput: one item per cycle; the whole datapath stalls only when both output buffer
//   entries are full and the sink is not ready
// depth is set by the 32-stage square root and the 34-stage divider, one bit per stage
// reset: asynchronous, active low; clears all valid bits and the output buffer and loads the
//   box registers with an unrotated box of zero size at the origin
module rounded_box_circle_pushout_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // circle item
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // circle_x[31:0], circle_y[63:32], circle_radius[94:64]
  // push item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // push_x[31:0], push_y[63:32]
  output logic        m_axis_tuser,   // overlapping
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [rbcp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rbcp_pkg::*;

  // ---------------------------------------------------------------- box registers
  logic signed [31:0] cx_q, cy_q;
  logic [30:0]        hw_q, hh_q, cr_q;
  logic signed [15:0] cos_q, sin_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      hw_q  <= '0;
      hh_q  <= '0;
      cr_q  <= '0;
      cos_q <= 16'sh4000;
      sin_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_CENTER_X:      cx_q  <= pwdata;
        REG_CENTER_Y:      cy_q  <= pwdata;
        REG_HALF_WIDTH:    hw_q  <= pwdata[30:0];
        REG_HALF_HEIGHT:   hh_q  <= pwdata[30:0];
        REG_CORNER_RADIUS: cr_q  <= pwdata[30:0];
        REG_COS_ANGLE:     cos_q <= pwdata[15:0];
        REG_SIN_ANGLE:     sin_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_CENTER_X:      prdata = cx_q;
      REG_CENTER_Y:      prdata = cy_q;
      REG_HALF_WIDTH:    prdata = {1'b0, hw_q};
      REG_HALF_HEIGHT:   prdata = {1'b0, hh_q};
      REG_CORNER_RADIUS: prdata = {1'b0, cr_q};
      REG_COS_ANGLE:     prdata = 32'(cos_q);
      REG_SIN_ANGLE:     prdata = 32'(sin_q);
      default:           prdata = '0;
    endcase
  end

  // global advance: the pipe moves unless the output buffer is full and blocked
  logic en;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------- s1: offsets from centre
  logic               v1_q;
  logic signed [32:0] dx1_q, dy1_q, dx1_d, dy1_d;
  logic [31:0]        r1_q, r1_d;

  always_comb begin
    dx1_d = {s_axis_tdata[31], s_axis_tdata[31:0]} - {cx_q[31], cx_q};
    dy1_d = {s_axis_tdata[63], s_axis_tdata[63:32]} - {cy_q[31], cy_q};
    r1_d  = {1'b0, s_axis_tdata[94:64]} + {1'b0, cr_q};   // combined radius
  end

  // ---------------------------------------------------------------- s2: rotation products
  logic               v2_q;
  logic signed [48:0] xc2_q, ys2_q, yc2_q, xs2_q, xc2_d, ys2_d, yc2_d, xs2_d;
  logic [31:0]        r2_q;

  always_comb begin
    xc2_d = dx1_q * cos_q;
    ys2_d = dy1_q * sin_q;
    yc2_d = dy1_q * cos_q;
    xs2_d = dx1_q * sin_q;
  end

  // ---------------------------------------------------------------- s3: local coordinates
  logic               v3_q;
  logic signed [49:0] lxs, lys;
  logic signed [35:0] lx3_q, ly3_q, lx3_d, ly3_d;
  logic [31:0]        r3_q;

  always_comb begin
    lxs   = xc2_q + ys2_q + 50'sd8192;   // round half up before the shift
    lys   = yc2_q - xs2_q + 50'sd8192;
    lx3_d = lxs[49:14];
    ly3_d = lys[49:14];
  end

  // ---------------------------------------------------------------- s4: clamp and classify
  logic               v4_q;
  logic signed [35:0] hw_s, hh_s, lx_abs, ly_abs, ax_s, ay_s, mx_s, my_s;
  logic               inx, iny, in_box;
  logic [31:0]        a4_q, b4_q, a4_d, b4_d, r4_q;
  logic               in4_q, sm4_q, nx4_q, ny4_q, in4_d, sm4_d, nx4_d, ny4_d;

  always_comb begin
    hw_s   = $signed({5'b0, hw_q});
    hh_s   = $signed({5'b0, hh_q});
    inx    = (lx3_q >= -hw_s) && (lx3_q <= hw_s);
    iny    = (ly3_q >= -hh_s) && (ly3_q <= hh_s);
    in_box = inx && iny;
    lx_abs = lx3_q[35] ? -lx3_q : lx3_q;
    ly_abs = ly3_q[35] ? -ly3_q : ly3_q;
    ax_s   = hw_s - lx_abs;               // clearance to the edge when inside
    ay_s   = hh_s - ly_abs;
    // distance from the clamped point, zero on an axis where the centre is inside
    if (lx3_q > hw_s)       mx_s = lx3_q - hw_s;
    else if (lx3_q < -hw_s) mx_s = -hw_s - lx3_q;
    else                    mx_s = '0;
    if (ly3_q > hh_s)       my_s = ly3_q - hh_s;
    else if (ly3_q < -hh_s) my_s = -hh_s - ly3_q;
    else                    my_s = '0;
    in4_d = in_box;
    sm4_d = ($unsigned(mx_s) < 36'(r3_q)) && ($unsigned(my_s) < 36'(r3_q));
    a4_d  = in_box ? ax_s[31:0] : mx_s[31:0];
    b4_d  = in_box ? ay_s[31:0] : my_s[31:0];
    nx4_d = in_box ? !(lx3_q > 36'sd0) : (lx3_q < -hw_s);
    ny4_d = in_box ? !(ly3_q > 36'sd0) : (ly3_q < -hh_s);
  end

  // ---------------------------------------------------------------- s5: squares
  logic        v5_q;
  logic [63:0] aa5_q, bb5_q, rr5_q;
  logic [31:0] a5_q, b5_q, r5_q;
  logic        in5_q, sm5_q, nx5_q, ny5_q;

  // ---------------------------------------------------------------- s6: case decision
  logic        v6_q;
  logic [64:0] sum65;
  logic        sum_lt, sum_nz;
  logic [63:0] rada6_q, radb6_q;
  sq_side_t    side6_q, side6_d;

  always_comb begin
    sum65 = {1'b0, aa5_q} + {1'b0, bb5_q};
    sum_lt = sum65 < {1'b0, rr5_q};
    sum_nz = (sum65 != 65'd0);
    side6_d.a     = a5_q;
    side6_d.b     = b5_q;
    side6_d.r     = r5_q;
    side6_d.neg_x = nx5_q;
    side6_d.neg_y = ny5_q;
    if (in5_q) begin
      if (sum_lt)              side6_d.mode = sum_nz ? MODE_CORNER : MODE_ZERO;
      else if (a5_q < b5_q)    side6_d.mode = MODE_AXIS_X;
      else                     side6_d.mode = MODE_AXIS_Y;   // ties go to y
    end else if (sm5_q && !sum65[64] && sum_lt && sum_nz) begin
      side6_d.mode = MODE_OUTSIDE;
    end else begin
      side6_d.mode = MODE_ZERO;
    end
  end

  // ---------------------------------------------------------------- square roots
  logic                         sq_vld;
  logic [ROOT_W-1:0]            root_a, root_b;
  logic [$bits(sq_side_t)-1:0]  sq_side_vec;
  sq_side_t                     sq_out;

  rbcp_sqrt_pipe #(
    .SideW ($bits(sq_side_t))
  ) u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v6_q),
    .rad_a_i  (rada6_q),
    .rad_b_i  (radb6_q),
    .side_i   (side6_q),
    .valid_o  (sq_vld),
    .root_a_o (root_a),
    .root_b_o (root_b),
    .side_o   (sq_side_vec)
  );

  assign sq_out = sq_side_vec;

  // ---------------------------------------------------------------- p1: scale factor and divisor
  logic        v7_q;
  logic [32:0] k7_q, k7_d;
  logic [31:0] d7_q, d7_d, a7_q, b7_q;
  dv_side_t    dv7_q, dv7_d;

  always_comb begin
    dv7_d.mode   = sq_out.mode;
    dv7_d.neg_x  = sq_out.neg_x;
    dv7_d.neg_y  = sq_out.neg_y;
    dv7_d.axis_v = ((sq_out.mode == MODE_AXIS_X) ? {1'b0, sq_out.a} : {1'b0, sq_out.b})
                   + {1'b0, sq_out.r};
    case (sq_out.mode)
      MODE_CORNER: begin
        k7_d = {1'b0, root_a} + {1'b0, root_b};   // length t plus the radius remainder
        d7_d = root_a;
      end
      MODE_OUTSIDE: begin
        k7_d = {1'b0, sq_out.r - root_a};          // remaining overlap
        d7_d = root_a;
      end
      default: begin
        k7_d = '0;
        d7_d = 32'd1;
      end
    endcase
  end

  // ---------------------------------------------------------------- p2: split products
  logic        v8_q;
  logic [48:0] alo8_q, blo8_q;
  logic [47:0] ahi8_q, bhi8_q;
  logic [31:0] d8_q;
  dv_side_t    dv8_q;

  // ---------------------------------------------------------------- p3: numerators
  logic        v9_q;
  logic [63:0] nx9_q, ny9_q, nx9_d, ny9_d;
  logic [31:0] d9_q;
  dv_side_t    dv9_q;

  always_comb begin
    nx9_d = 64'(alo8_q) + {ahi8_q[46:0], 17'b0};
    ny9_d = 64'(blo8_q) + {bhi8_q[46:0], 17'b0};
  end

  // ---------------------------------------------------------------- division
  logic                        dv_vld;
  logic [QUOT_W-1:0]           qx, qy;
  logic [$bits(dv_side_t)-1:0] dv_side_vec;
  dv_side_t                    dv_out;

  rbcp_div_pipe #(
    .SideW ($bits(dv_side_t))
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v9_q),
    .num_x_i  (nx9_q),
    .num_y_i  (ny9_q),
    .den_i    (d9_q),
    .side_i   (dv9_q),
    .valid_o  (dv_vld),
    .quot_x_o (qx),
    .quot_y_o (qy),
    .side_o   (dv_side_vec)
  );

  assign dv_out = dv_side_vec;

  // ---------------------------------------------------------------- f1: signed local push
  logic               v10_q;
  logic [34:0]        magx, magy;
  logic signed [35:0] px10_q, py10_q, px10_d, py10_d;

  always_comb begin
    magx = '0;
    magy = '0;
    if (dv_out.mode inside {MODE_CORNER, MODE_OUTSIDE}) begin
      magx = {1'b0, qx};
      magy = {1'b0, qy};
    end else if (dv_out.mode == MODE_AXIS_X) begin
      magx = {2'b0, dv_out.axis_v};
    end else if (dv_out.mode == MODE_AXIS_Y) begin
      magy = {2'b0, dv_out.axis_v};
    end
    px10_d = dv_out.neg_x ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
    py10_d = dv_out.neg_y ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
  end

  // ---------------------------------------------------------------- f2: back-rotation products
  logic               v11_q;
  logic signed [51:0] xc11_q, ys11_q, xs11_q, yc11_q;

  // ---------------------------------------------------------------- f3: world sums
  logic               v12_q;
  logic signed [52:0] wx12_q, wy12_q, wx12_d, wy12_d;

  always_comb begin
    wx12_d = xc11_q - ys11_q + 53'sd8192;
    wy12_d = xs11_q + yc11_q + 53'sd8192;
  end

  // ---------------------------------------------------------------- saturation and output
  logic [31:0]      wx_sat, wy_sat;
  logic [OUT_W-1:0] buf_in, buf_out;

  always_comb begin
    wx_sat = sat_w(wx12_q[52:14]);
    wy_sat = sat_w(wy12_q[52:14]);
    buf_in = {(wx_sat != 32'd0) || (wy_sat != 32'd0), wy_sat, wx_sat};
  end

  rbcp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (en && v12_q),
    .data_i      (buf_in),
    .ready_o     (en),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (buf_out)
  );

  assign m_axis_tdata = buf_out[63:0];
  assign m_axis_tuser = buf_out[64];

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else if (en) begin
      v1_q  <= s_axis_tvalid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= sq_vld;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= dv_vld;
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q   <= dx1_d;
      dy1_q   <= dy1_d;
      r1_q    <= r1_d;

      xc2_q   <= xc2_d;
      ys2_q   <= ys2_d;
      yc2_q   <= yc2_d;
      xs2_q   <= xs2_d;
      r2_q    <= r1_q;

      lx3_q   <= lx3_d;
      ly3_q   <= ly3_d;
      r3_q    <= r2_q;

      a4_q    <= a4_d;
      b4_q    <= b4_d;
      r4_q    <= r3_q;
      in4_q   <= in4_d;
      sm4_q   <= sm4_d;
      nx4_q   <= nx4_d;
      ny4_q   <= ny4_d;

      aa5_q   <= a4_q * a4_q;
      bb5_q   <= b4_q * b4_q;
      rr5_q   <= r4_q * r4_q;
      a5_q    <= a4_q;
      b5_q    <= b4_q;
      r5_q    <= r4_q;
      in5_q   <= in4_q;
      sm5_q   <= sm4_q;
      nx5_q   <= nx4_q;
      ny5_q   <= ny4_q;

      rada6_q <= sum65[63:0];
      radb6_q <= rr5_q - sum65[63:0];
      side6_q <= side6_d;

      k7_q    <= k7_d;
      d7_q    <= d7_d;
      a7_q    <= sq_out.a;
      b7_q    <= sq_out.b;
      dv7_q   <= dv7_d;

      alo8_q  <= a7_q * k7_q[16:0];
      ahi8_q  <= a7_q * k7_q[32:17];
      blo8_q  <= b7_q * k7_q[16:0];
      bhi8_q  <= b7_q * k7_q[32:17];
      d8_q    <= d7_q;
      dv8_q   <= dv7_q;

      nx9_q   <= nx9_d;
      ny9_q   <= ny9_d;
      d9_q    <= d8_q;
      dv9_q   <= dv8_q;

      px10_q  <= px10_d;
      py10_q  <= py10_d;

      xc11_q  <= px10_q * cos_q;
      ys11_q  <= py10_q * sin_q;
      xs11_q  <= px10_q * sin_q;
      yc11_q  <= py10_q * cos_q;

      wx12_q  <= wx12_d;
      wy12_q  <= wy12_d;
    end
  end

endmodule

[src/rbcp_checker.sv]
// port-level checks for the push-out core and their binding
`include "rounded_box_circle_pushout_core_macros.svh"

module rbcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled item holds its data
  `RBCP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled push item changed")

  // no overlap means a zero push
  `RBCP_ASSERT_NOW(a_zero_push, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 64'd0, "push nonzero without overlap flag")

  // overlap flag only with a nonzero push
  `RBCP_ASSERT_NOW(a_flag_push, m_axis_tvalid && m_axis_tuser, m_axis_tdata != 64'd0, "overlap flag with zero push")

  // an empty output buffer never blocks the input
  `RBCP_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")

endmodule

bind rounded_box_circle_pushout_core rbcp_checker u_rbcp_checker (.*);
